FILE: sv/qslp_pkg.sv
`timescale 1ns / 1ps
// Package for the quaternion slerp pipeline: formats, CORDIC table,
// stage timing and the structs shared by the pipeline modules. No dependencies.
package qslp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [33:0] GAIN_Q30  = 34'd652032874;
    localparam logic [15:0] BLEND_ONE = 16'h8000;
    localparam logic [30:0] THR_RESET = 31'd10737;

    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
        31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
        31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
        31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
        31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F, 31'h0000003F,
        31'h0000001F, 31'h0000000F, 31'h00000008, 31'h00000004, 31'h00000002,
        31'h00000001, 31'h00000000
    };

    // latencies and the cycle at which each unit takes its operands
    localparam int LAT_SQRT  = 32;
    localparam int LAT_DIV   = 32;
    localparam int T_SQRT    = 3;
    localparam int T_VEC     = T_SQRT + LAT_SQRT;
    localparam int T_ROT     = T_VEC + CORDIC_N;
    localparam int T_DIV     = T_ROT + CORDIC_N + 1;
    localparam int T_BACK    = T_DIV + LAT_DIV;
    localparam int LAT_TOTAL = T_BACK + 2;

    typedef struct packed {
        logic [3:0][15:0] f;
        logic [3:0][15:0] t;
        logic [15:0]      blend;
    } t_req;

    typedef struct packed {
        logic [3:0][15:0] cf;
        logic [3:0][16:0] ct;
        logic [15:0]      a;
        logic             sph;
    } t_side;

endpackage

FILE: sv/qslp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the slerp request and result streams.
// No dependencies.
interface qslp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] from_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic signed [15:0] to_w;
    logic        [15:0] blend;

    modport source(output valid, from_x, from_y, from_z, from_w,
                   to_x, to_y, to_z, to_w, blend, input ready);
    modport sink(input valid, from_x, from_y, from_z, from_w,
                 to_x, to_y, to_z, to_w, blend, output ready);
endinterface

interface qslp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
    logic               used_linear;

    modport source(output valid, out_x, out_y, out_z, out_w, used_linear,
                   input ready);
    modport sink(input valid, out_x, out_y, out_z, out_w, used_linear,
                 output ready);
endinterface

FILE: sv/qslp_front.sv
`timescale 1ns / 1ps
// Front end: dot product, sign fold, threshold test and dc^2 (3 stages).
// Depends on qslp_pkg.
module qslp_front (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [30:0]       i_thr,
    input  qslp_pkg::t_req    i_req,
    output logic [30:0]       o_dc,
    output logic [61:0]       o_dsq,
    output qslp_pkg::t_side   o_side
);

    logic signed [31:0] r_p [4];
    qslp_pkg::t_req     r_req1;
    logic [15:0]        r_a1;

    logic signed [33:0] d;
    logic [32:0]        dabs;
    logic signed [34:0] margin;
    qslp_pkg::t_side    n_side2;
    logic [30:0]        n_dc2;

    qslp_pkg::t_side    r_side2;
    logic [30:0]        r_dc2;
    qslp_pkg::t_side    r_side3;
    logic [30:0]        r_dc3;
    logic [61:0]        r_dsq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_p[j] <= 32'($signed(i_req.f[j])) * 32'($signed(i_req.t[j]));
            end
            r_req1 <= i_req;
            r_a1   <= (i_req.blend > qslp_pkg::BLEND_ONE) ? qslp_pkg::BLEND_ONE : i_req.blend;
        end
    end

    always_comb begin
        logic signed [16:0] te;
        d = 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]) + 34'(r_p[3]);
        dabs = d[33] ? 33'(-d) : 33'(d);
        n_dc2 = (dabs > 33'(qslp_pkg::ONE_Q30)) ? qslp_pkg::ONE_Q30 : dabs[30:0];
        margin = $signed({4'b0, qslp_pkg::ONE_Q30}) - $signed({2'b0, dabs});
        n_side2.sph = margin > $signed({4'b0, i_thr});
        n_side2.a   = r_a1;
        n_side2.cf  = r_req1.f;
        for (int j = 0; j < 4; j++) begin
            te = {r_req1.t[j][15], r_req1.t[j]};
            n_side2.ct[j] = d[33] ? 17'(-te) : te;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side2 <= n_side2;
            r_dc2   <= n_dc2;
            r_side3 <= r_side2;
            r_dc3   <= r_dc2;
            r_dsq   <= 62'(r_dc2) * 62'(r_dc2);
        end
    end

    assign o_dc   = r_dc3;
    assign o_dsq  = r_dsq;
    assign o_side = r_side3;

endmodule

FILE: sv/qslp_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of 2^60 - dsq, one result bit per stage.
// Depends on qslp_pkg (LAT_SQRT).
module qslp_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_dsq,
    output logic [30:0] o_root
);

    localparam int NB = qslp_pkg::LAT_SQRT - 1;

    logic [62:0] r_rem  [0:NB];
    logic [30:0] r_root [0:NB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (63'(1) << 60) - 63'(i_dsq);
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_bit
        localparam int B = NB - 1 - k;
        logic [62:0] cmp;
        assign cmp = (63'(r_root[k]) << (B + 1)) + (63'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= cmp) begin
                    r_rem[k+1]  <= r_rem[k] - cmp;
                    r_root[k+1] <= r_root[k] | (31'(1) << B);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
            end
        end
    end

    assign o_root = r_root[NB];

endmodule

FILE: sv/qslp_cordic_vec.sv
`timescale 1ns / 1ps
// CORDIC vectoring: theta = atan2(s, dc), one micro-rotation per stage.
// Depends on qslp_pkg (CORDIC_N, ATAN_Q30).
module qslp_cordic_vec (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_dc,
    input  logic [30:0] i_s,
    output logic [30:0] o_theta
);

    localparam int N = qslp_pkg::CORDIC_N;

    logic signed [33:0] r_x [1:N];
    logic signed [33:0] r_y [1:N];
    logic signed [33:0] r_z [1:N];

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic signed [33:0] at;
        assign at = $signed({3'b0, qslp_pkg::ATAN_Q30[i]});
        if (i == 0) begin : g_first
            assign x = $signed({3'b0, i_dc});
            assign y = $signed({3'b0, i_s});
            assign z = '0;
        end else begin : g_next
            assign x = r_x[i];
            assign y = r_y[i];
            assign z = r_z[i];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y >= 0) begin
                    r_x[i+1] <= x + (y >>> i);
                    r_y[i+1] <= y - (x >>> i);
                    r_z[i+1] <= z + at;
                end else begin
                    r_x[i+1] <= x - (y >>> i);
                    r_y[i+1] <= y + (x >>> i);
                    r_z[i+1] <= z - at;
                end
            end
        end
    end

    assign o_theta = r_z[N][33] ? '0 : r_z[N][30:0];

endmodule

FILE: sv/qslp_cordic_rot.sv
`timescale 1ns / 1ps
// Scales theta by k/32768, then CORDIC rotation for the sine, clamped at 0.
// Depends on qslp_pkg (CORDIC_N, GAIN_Q30, ATAN_Q30).
module qslp_cordic_rot (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_theta,
    input  logic [15:0] i_k,
    output logic [31:0] o_sin
);

    localparam int N = qslp_pkg::CORDIC_N;

    logic [46:0]        prod;
    logic [30:0]        r_ang;
    logic signed [33:0] r_x [1:N];
    logic signed [33:0] r_y [1:N];
    logic signed [33:0] r_z [1:N];

    assign prod = 47'(i_theta) * 47'(i_k);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= prod[45:15];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic signed [33:0] at;
        assign at = $signed({3'b0, qslp_pkg::ATAN_Q30[i]});
        if (i == 0) begin : g_first
            assign x = $signed(qslp_pkg::GAIN_Q30);
            assign y = '0;
            assign z = $signed({3'b0, r_ang});
        end else begin : g_next
            assign x = r_x[i];
            assign y = r_y[i];
            assign z = r_z[i];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z >= 0) begin
                    r_x[i+1] <= x - (y >>> i);
                    r_y[i+1] <= y + (x >>> i);
                    r_z[i+1] <= z - at;
                end else begin
                    r_x[i+1] <= x + (y >>> i);
                    r_y[i+1] <= y - (x >>> i);
                    r_z[i+1] <= z + at;
                end
            end
        end
    end

    assign o_sin = r_y[N][33] ? '0 : r_y[N][31:0];

endmodule

FILE: sv/qslp_div.sv
`timescale 1ns / 1ps
// Restoring divider: w = min(floor(sin * 2^30 / s), 2^30), one bit per stage.
// Depends on qslp_pkg (LAT_DIV, ONE_Q30).
module qslp_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_sin,
    input  logic [30:0] i_s,
    output logic [30:0] o_w
);

    localparam int NB = qslp_pkg::LAT_DIV - 1;

    logic [62:0] r_rem [0:NB];
    logic [30:0] r_q   [0:NB];
    logic [30:0] r_s   [0:NB];
    logic        r_ovf [0:NB];

    // quotient of 2^31 or more saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_sin[31:0], 30'b0};
            r_q[0]   <= '0;
            r_s[0]   <= i_s;
            r_ovf[0] <= i_sin >= {i_s, 1'b0};
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_bit
        localparam int B = NB - 1 - k;
        logic [62:0] sub;
        assign sub = 63'(r_s[k]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k+1]   <= r_s[k];
                r_ovf[k+1] <= r_ovf[k];
                if (r_rem[k] >= sub) begin
                    r_rem[k+1] <= r_rem[k] - sub;
                    r_q[k+1]   <= r_q[k] | (31'(1) << B);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
            end
        end
    end

    assign o_w = (r_ovf[NB] || r_q[NB] > qslp_pkg::ONE_Q30) ? qslp_pkg::ONE_Q30 : r_q[NB];

endmodule

FILE: sv/qslp_back.sv
`timescale 1ns / 1ps
// Back end: weight select, weighted sum, rounding and saturation (2 stages).
// Depends on qslp_pkg.
module qslp_back (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [30:0]       i_wf,
    input  logic [30:0]       i_wt,
    input  logic              i_s_nz,
    input  qslp_pkg::t_side   i_side,
    output logic [3:0][15:0]  o_comp,
    output logic              o_linear
);

    localparam logic signed [49:0] RND = 50'sh2000_0000;

    logic               lin;
    logic [30:0]        wf;
    logic [30:0]        wt;
    logic signed [47:0] r_pf [4];
    logic signed [48:0] r_pt [4];
    logic               r_lin;
    logic [3:0][15:0]   r_comp;
    logic               r_linear;

    always_comb begin
        lin = !(i_side.sph && i_s_nz);
        wt  = lin ? {i_side.a, 15'b0} : i_wt;
        wf  = lin ? (qslp_pkg::ONE_Q30 - {i_side.a, 15'b0}) : i_wf;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_pf[j] <= 48'($signed({1'b0, wf})) * 48'($signed(i_side.cf[j]));
                r_pt[j] <= 49'($signed({1'b0, wt})) * 49'($signed(i_side.ct[j]));
            end
            r_lin <= lin;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [49:0] acc;
        logic signed [49:0] sh;
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                acc = 50'(r_pf[j]) + 50'(r_pt[j]) + RND;
                sh  = acc >>> 30;
                if (sh > 50'sd32767) begin
                    r_comp[j] <= 16'h7FFF;
                end else if (sh < -50'sd32768) begin
                    r_comp[j] <= 16'h8000;
                end else begin
                    r_comp[j] <= sh[15:0];
                end
            end
            r_linear <= r_lin;
        end
    end

    assign o_comp   = r_comp;
    assign o_linear = r_linear;

endmodule

FILE: sv/quaternion_slerp.sv
`timescale 1ns / 1ps
// Top level of the quaternion slerp pipeline: front end, square root, CORDIC
// vectoring, two CORDIC rotations, two dividers, back end. Depends on all sv files.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    from_x..from_w, to_x..to_w, blend
//  o_out     out  valid/ready    out_x..out_w, used_linear
//  cfg       in   i_cfg_we       i_cfg_wdata (lerp_threshold)
//
// One transaction per cycle sustained while the output is not stalled; the
// pipeline depth is set by the bit-per-stage square root and dividers and the
// CORDIC stages. The whole pipeline advances together; it holds while the
// output transaction is stalled. Synchronous active-low reset clears the valid
// bits and loads the threshold register with THR_RESET.
module quaternion_slerp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qslp_in_if.sink     i_in,
    qslp_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);

    localparam int LT     = qslp_pkg::LAT_TOTAL;
    localparam int D_SIDE = qslp_pkg::T_BACK - 3;
    localparam int D_S    = qslp_pkg::T_BACK - 35;

    logic            en;
    logic [30:0]     r_thr;
    logic [LT-1:0]   r_vld;
    qslp_pkg::t_req  req;
    qslp_pkg::t_side side0;
    logic [30:0]     dc0;
    logic [61:0]     dsq0;
    logic [30:0]     s_root;
    logic [30:0]     theta;
    logic [31:0]     sin_f;
    logic [31:0]     sin_t;
    logic [30:0]     w_f;
    logic [30:0]     w_t;
    logic [15:0]     k_f;
    logic [3:0][15:0] comp;
    logic            linear;

    qslp_pkg::t_side r_side [0:D_SIDE-1];
    logic [30:0]     r_dc   [0:qslp_pkg::LAT_SQRT-1];
    logic [30:0]     r_s    [0:D_S-1];

    assign en         = !r_vld[LT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qslp_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LT-2:0], i_in.valid};
        end
    end

    assign req.f     = {i_in.from_w, i_in.from_z, i_in.from_y, i_in.from_x};
    assign req.t     = {i_in.to_w, i_in.to_z, i_in.to_y, i_in.to_x};
    assign req.blend = i_in.blend;

    qslp_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_thr  (r_thr),
        .i_req  (req),
        .o_dc   (dc0),
        .o_dsq  (dsq0),
        .o_side (side0)
    );

    qslp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dsq  (dsq0),
        .o_root (s_root)
    );

    // sideband delay lines for side0, dc0 and s_root, advancing with en
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side0;
            for (int j = 1; j < D_SIDE; j++) begin
                r_side[j] <= r_side[j-1];
            end
            r_dc[0] <= dc0;
            for (int j = 1; j < qslp_pkg::LAT_SQRT; j++) begin
                r_dc[j] <= r_dc[j-1];
            end
            r_s[0] <= s_root;
            for (int j = 1; j < D_S; j++) begin
                r_s[j] <= r_s[j-1];
            end
        end
    end

    qslp_cordic_vec u_vec (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dc    (r_dc[qslp_pkg::LAT_SQRT-1]),
        .i_s     (s_root),
        .o_theta (theta)
    );

    assign k_f = qslp_pkg::BLEND_ONE - r_side[qslp_pkg::T_ROT-4].a;

    qslp_cordic_rot u_rot_f (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_theta (theta),
        .i_k     (k_f),
        .o_sin   (sin_f)
    );

    qslp_cordic_rot u_rot_t (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_theta (theta),
        .i_k     (r_side[qslp_pkg::T_ROT-4].a),
        .o_sin   (sin_t)
    );

    qslp_div u_div_f (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sin (sin_f),
        .i_s   (r_s[qslp_pkg::T_DIV-36]),
        .o_w   (w_f)
    );

    qslp_div u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sin (sin_t),
        .i_s   (r_s[qslp_pkg::T_DIV-36]),
        .o_w   (w_t)
    );

    qslp_back u_back (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_wf     (w_f),
        .i_wt     (w_t),
        .i_s_nz   (r_s[D_S-1] != '0),
        .i_side   (r_side[D_SIDE-1]),
        .o_comp   (comp),
        .o_linear (linear)
    );

    assign o_out.valid       = r_vld[LT-1];
    assign o_out.out_x       = comp[0];
    assign o_out.out_y       = comp[1];
    assign o_out.out_z       = comp[2];
    assign o_out.out_w       = comp[3];
    assign o_out.used_linear = linear;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_slerp: a predictor and scoreboard
// class with directed and random traffic. Depends on qslp_pkg, qslp_if and the RTL.
module testbench;

    typedef struct {
        logic signed [15:0] f [4];
        logic signed [15:0] t [4];
        logic        [15:0] blend;
    } t_slerp_req;

    typedef struct {
        logic signed [15:0] q [4];
        logic               lin;
    } t_slerp_res;

    class slerp_scoreboard;
        t_slerp_res  pending [$];
        longint      threshold;
        int          errors;

        function new();
            threshold = qslp_pkg::THR_RESET;
            errors    = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint vec_angle(longint x, longint y);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < qslp_pkg::CORDIC_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(qslp_pkg::ATAN_Q30[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(qslp_pkg::ATAN_Q30[i]);
                end
            end
            return z;
        endfunction

        function longint rot_sine(longint z);
            longint x, y, dx, dy;
            x = longint'(qslp_pkg::GAIN_Q30);
            y = 0;
            for (int i = 0; i < qslp_pkg::CORDIC_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(qslp_pkg::ATAN_Q30[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(qslp_pkg::ATAN_Q30[i]);
                end
            end
            return (y < 0) ? 0 : y;
        endfunction

        function longint sph_weight(longint theta, longint k, longint s);
            longint unsigned ang, w;
            longint sn;
            ang = (longint'(theta) * k) >> 15;
            sn  = rot_sine(longint'(ang));
            w   = (longint'(sn) << 30) / s;
            return (w > (64'd1 << 30)) ? (64'sd1 << 30) : longint'(w);
        endfunction

        function void note_input(t_slerp_req r);
            longint f [4], t [4];
            longint dot, d, dc, s, theta, wf, wt, acc, a;
            t_slerp_res e;
            a = (r.blend > qslp_pkg::BLEND_ONE) ? 32768 : longint'(r.blend);
            dot = 0;
            for (int j = 0; j < 4; j++) begin
                f[j] = longint'(r.f[j]) <<< 15;
                t[j] = longint'(r.t[j]) <<< 15;
                dot += f[j] * t[j];
            end
            if (dot < 0) begin
                dot = -dot;
                for (int j = 0; j < 4; j++) t[j] = -t[j];
            end
            d = dot >>> 30;
            e.lin = 1'b1;
            if ((64'sd1 << 30) - d > threshold) begin
                dc = (d > (64'sd1 << 30)) ? (64'sd1 << 30) : d;
                s  = int_sqrt((64'd1 << 60) - dc * dc);
                if (s > 0) begin
                    theta = vec_angle(dc, s);
                    if (theta < 0) theta = 0;
                    wf = sph_weight(theta, 32768 - a, s);
                    wt = sph_weight(theta, a, s);
                    e.lin = 1'b0;
                end
            end
            if (e.lin) begin
                wt = a << 15;
                wf = (64'sd1 << 30) - wt;
            end
            for (int j = 0; j < 4; j++) begin
                acc = wf * f[j] + wt * t[j] + (64'sd1 << 44);
                acc = acc >>> 45;
                if (acc > 32767)  acc = 32767;
                if (acc < -32768) acc = -32768;
                e.q[j] = acc[15:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_slerp_res g);
            t_slerp_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, g);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int j = 0; j < 4; j++)
                if (g.q[j] !== e.q[j]) begin
                    $display("%0t: component %0d expected %0d actual %0d",
                             $realtime, j, e.q[j], g.q[j]);
                    errors++;
                end
            if (g.lin !== e.lin) begin
                $display("%0t: used_linear expected %0b actual %0b",
                         $realtime, e.lin, g.lin);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [30:0] i_cfg_wdata;

    qslp_in_if  req_ch();
    qslp_out_if res_ch();

    quaternion_slerp dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    slerp_scoreboard sb;
    bit              hold_off_req;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #5000000;
        $display("[quaternion_slerp] ERROR");
        $finish;
    end

    // receiver: stall pattern plus one long hold-off on request
    initial begin
        int mode, left, hold;
        t_slerp_res g;
        res_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(5, 80);
            end
            left--;
            if (hold > 0) begin
                hold--;
                res_ch.ready = 1'b0;
            end else begin
                case (mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = 1'($urandom_range(0, 1));
                    default: res_ch.ready = ($urandom_range(0, 4) == 0);
                endcase
            end
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                g.q[0] = res_ch.out_x;
                g.q[1] = res_ch.out_y;
                g.q[2] = res_ch.out_z;
                g.q[3] = res_ch.out_w;
                g.lin  = res_ch.used_linear;
                sb.check_result(g);
            end
        end
    end

    int burst_left;

    task automatic send(t_slerp_req r);
        req_ch.valid  = 1'b1;
        req_ch.from_x = r.f[0];
        req_ch.from_y = r.f[1];
        req_ch.from_z = r.f[2];
        req_ch.from_w = r.f[3];
        req_ch.to_x   = r.t[0];
        req_ch.to_y   = r.t[1];
        req_ch.to_z   = r.t[2];
        req_ch.to_w   = r.t[3];
        req_ch.blend  = r.blend;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_input(r);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (qslp_pkg::LAT_TOTAL + 10) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [30:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.threshold = v;
    endtask

    function automatic logic signed [15:0] rnd_comp();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void unit_quat(output logic signed [15:0] q [4]);
        real v [4], n;
        n = 0.0;
        while (n < 0.01) begin
            n = 0.0;
            for (int j = 0; j < 4; j++) begin
                v[j] = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
                n += v[j] * v[j];
            end
        end
        n = $sqrt(n);
        for (int j = 0; j < 4; j++) q[j] = 16'($rtoi(v[j] / n * 32767.0));
    endfunction

    function automatic t_slerp_req random_req();
        t_slerp_req r;
        int kind, dev;
        kind = $urandom_range(0, 9);
        unit_quat(r.f);
        if (kind < 5) begin
            unit_quat(r.t);
        end else if (kind < 8) begin
            dev = 1 << $urandom_range(0, 11);
            for (int j = 0; j < 4; j++) begin
                r.t[j] = 16'(r.f[j] + $signed($urandom_range(0, 2 * dev)) - dev);
                if ($urandom_range(0, 1) && kind == 7) r.t[j] = -r.t[j];
            end
        end else begin
            for (int j = 0; j < 4; j++) begin
                r.f[j] = rnd_comp();
                r.t[j] = rnd_comp();
            end
        end
        if ($urandom_range(0, 9) == 0) r.blend = 16'($urandom_range(0, 65535));
        else r.blend = 16'($urandom_range(0, 32768));
        return r;
    endfunction

    initial begin
        t_slerp_req  r;
        logic [30:0] thr [5];
        sb = new();
        hold_off_req = 1'b0;
        burst_left   = 0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_ch.valid = 1'b0;
        req_ch.from_x = '0; req_ch.from_y = '0; req_ch.from_z = '0; req_ch.from_w = '0;
        req_ch.to_x   = '0; req_ch.to_y   = '0; req_ch.to_z   = '0; req_ch.to_w   = '0;
        req_ch.blend  = '0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, identical, opposite, orthogonal, oversize dot, blend over one
        for (int k = 0; k < 20; k++) begin
            for (int j = 0; j < 4; j++) begin
                r.f[j] = '0;
                r.t[j] = '0;
            end
            r.f[3] = 16'sd32767;
            case (k % 5)
                0: r.t[3] = 16'sd32767;
                1: r.t[3] = -16'sd32767;
                2: r.t[0] = 16'sd32767;
                3: begin
                    for (int j = 0; j < 4; j++) begin
                        r.f[j] = 16'sh8000;
                        r.t[j] = (k < 10) ? 16'sh8000 : 16'sd32767;
                    end
                end
                default: begin
                    r.t[1] = 16'sd23170;
                    r.t[3] = 16'sd23170;
                end
            endcase
            case (k / 5)
                0: r.blend = 16'd0;
                1: r.blend = 16'h8000;
                2: r.blend = 16'hFFFF;
                default: r.blend = 16'd16384;
            endcase
            send(r);
        end
        for (int j = 0; j < 4; j++) begin
            r.f[j] = '0;
            r.t[j] = '0;
        end
        r.blend = 16'd12345;
        send(r);
        drain();

        thr[0] = qslp_pkg::THR_RESET;
        thr[1] = 31'd0;
        thr[2] = 31'h4000_0000;
        thr[3] = 31'($urandom_range(0, 1 << 24));
        thr[4] = 31'h3FFF_FFFF;
        for (int p = 0; p < 5; p++) begin
            write_threshold(thr[p]);
            for (int n = 0; n < 316; n++) begin
                if (p == 1 && n == 100) hold_off_req = 1'b1;
                if (p == 2 && n == 150) drain();
                send(random_req());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[quaternion_slerp] OK");
        else
            $display("[quaternion_slerp] ERROR");
        $finish;
    end

endmodule
